// ===== rtl/ckd_pkg.sv =====
// ----------------------------------------------------------------------------
// ckd_pkg
// Shared types and constants for the console key sequence decoder: parse
// phases, character codes, key ids and the decoder result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ckd_pkg;

    // Number of function keys (F1-F10, SF1-SF10); fits the 5-bit number
    localparam int unsigned FUNC_KEY_COUNT = 20;
    localparam int unsigned NUM_W          = 5;

    // Configuration register indexes
    localparam logic CFG_EXT_KEYS = 1'b0;
    localparam logic CFG_MENU_KEY = 1'b1;

    // Key kind codes
    localparam logic KIND_PLAIN   = 1'b0;
    localparam logic KIND_SPECIAL = 1'b1;

    // Character codes
    localparam logic [7:0] CH_INTRO = 8'h9B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;

    // Special key ids (function keys take 0 .. FUNC_KEY_COUNT-1)
    localparam logic [7:0] KEY_UP     = 8'd20;
    localparam logic [7:0] KEY_DOWN   = 8'd21;
    localparam logic [7:0] KEY_RIGHT  = 8'd22;
    localparam logic [7:0] KEY_LEFT   = 8'd23;
    localparam logic [7:0] KEY_SUP    = 8'd24;
    localparam logic [7:0] KEY_SDOWN  = 8'd25;
    localparam logic [7:0] KEY_SLEFT  = 8'd26;
    localparam logic [7:0] KEY_SRIGHT = 8'd27;
    localparam logic [7:0] KEY_HELP   = 8'd28;
    localparam logic [7:0] KEY_MENU   = 8'd29;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CSI    = 3'd1,
        PH_SPACE  = 3'd2,
        PH_NUMBER = 3'd3,
        PH_HELP   = 3'd4,
        PH_MENU   = 3'd5
    } t_phase;

    // One decoded key
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } t_key;

    // Decoder outcome for one byte
    typedef struct packed {
        logic emit;
        t_key key;
    } t_dec_result;

    // Configuration bits seen by the decoder
    typedef struct packed {
        logic ext_keys;
        logic menu_key;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/ckd_decode.sv =====
// ----------------------------------------------------------------------------
// ckd_decode
// Parse state (phase and function number) plus the combinational decision
// for one byte: next state and an optional key.
// ----------------------------------------------------------------------------
`default_nettype none

module ckd_decode (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire [7:0]            i_byte,
    input  ckd_pkg::t_cfg        i_cfg,
    output ckd_pkg::t_dec_result o_result
);
    import ckd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [NUM_W-1:0]   r_number, n_number;
    logic               is_digit;
    logic [3:0]         digit_val;
    logic [7:0]         acc_base;
    logic [8:0]         acc_sum;
    logic [NUM_W-1:0]   acc_sat;
    t_dec_result        res;

    // Digit detect and value
    assign is_digit  = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit_val = i_byte[3:0];

    // number * 10 + digit, saturated at the table size
    assign acc_base = (r_phase == PH_NUMBER) ? {3'd0, r_number} : 8'd0;
    assign acc_sum  = {acc_base[5:0], 3'b000} + {acc_base, 1'b0}
                    + {5'd0, digit_val};
    assign acc_sat  = (acc_sum >= 9'(FUNC_KEY_COUNT)) ? NUM_W'(FUNC_KEY_COUNT)
                                                      : acc_sum[NUM_W-1:0];

    // Next phase and key
    always_comb begin
        n_phase          = PH_IDLE;
        n_number         = r_number;
        res.emit         = 1'b0;
        res.key.kind     = KIND_SPECIAL;
        res.key.value    = i_byte;
        unique case (r_phase)
            PH_CSI: begin
                if (i_byte == CH_M && i_cfg.menu_key) begin
                    n_phase = PH_MENU;
                end else if (i_cfg.ext_keys) begin
                    unique case (i_byte)
                        CH_QUEST: n_phase = PH_HELP;
                        CH_A: begin
                            res.emit = 1'b1;
                            res.key.value = KEY_UP;
                        end
                        CH_B: begin
                            res.emit = 1'b1;
                            res.key.value = KEY_DOWN;
                        end
                        CH_C: begin
                            res.emit = 1'b1;
                            res.key.value = KEY_RIGHT;
                        end
                        CH_D: begin
                            res.emit = 1'b1;
                            res.key.value = KEY_LEFT;
                        end
                        CH_T: begin
                            res.emit = 1'b1;
                            res.key.value = KEY_SUP;
                        end
                        CH_S: begin
                            res.emit = 1'b1;
                            res.key.value = KEY_SDOWN;
                        end
                        CH_SPACE: n_phase = PH_SPACE;
                        default: begin
                            if (is_digit) begin
                                n_number = acc_sat;
                                n_phase  = PH_NUMBER;
                            end
                        end
                    endcase
                end
            end
            PH_SPACE: begin
                if (i_byte == CH_A) begin
                    res.emit = 1'b1;
                    res.key.value = KEY_SLEFT;
                end else if (i_byte == CH_AT) begin
                    res.emit = 1'b1;
                    res.key.value = KEY_SRIGHT;
                end
            end
            PH_NUMBER: begin
                if (is_digit) begin
                    n_number = acc_sat;
                    n_phase  = PH_NUMBER;
                end else if (i_byte == CH_TILDE &&
                             r_number < NUM_W'(FUNC_KEY_COUNT)) begin
                    res.emit = 1'b1;
                    res.key.value = {{(8-NUM_W){1'b0}}, r_number};
                end
            end
            PH_HELP: begin
                res.emit = 1'b1;
                res.key.value = KEY_HELP;
            end
            PH_MENU: begin
                res.emit = 1'b1;
                res.key.value = KEY_MENU;
            end
            default: begin
                // idle: introducer opens a sequence, anything else passes
                if (i_byte == CH_INTRO) begin
                    n_phase = PH_CSI;
                end else begin
                    res.emit = 1'b1;
                    res.key.kind = KIND_PLAIN;
                end
            end
        endcase
    end

    assign o_result = res;

    // Parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_number <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_number <= n_number;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/console_key_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// console_key_sequence_decoder
// Console byte stream to key decoder: plain bytes pass through, introducer
// sequences become arrow, shift-arrow, help, menu and function keys.
// ----------------------------------------------------------------------------
// Path: input register, then decode into the result register.
// Throughput: one byte per cycle while the output is not stalled; the parse
//   state loop closes through the parse state register in ckd_decode.
// Reset (synchronous, active low): parser idle, number cleared, both enable
//   registers set, pipeline empty.
`default_nettype none

module console_key_sequence_decoder (
    input  wire       i_clk,
    input  wire       i_rst_n,
    // configuration
    input  wire       i_cfg_we,
    input  wire       i_cfg_index,
    input  wire       i_cfg_wdata,
    // byte input
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  wire [7:0] i_rx_byte,
    // key output
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output logic      o_key_kind,
    output logic [7:0] o_key_value
);
    import ckd_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_key        r_out_key;
    logic        out_free;
    logic        fire;
    t_dec_result dec;

    // Stage handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ext_keys <= 1'b1;
            r_cfg.menu_key <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXT_KEYS: r_cfg.ext_keys <= i_cfg_wdata;
                CFG_MENU_KEY: r_cfg.menu_key <= i_cfg_wdata;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parser
    ckd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (dec)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && dec.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && dec.emit) begin
            r_out_key <= dec.key;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_kind  = r_out_key.kind;
    assign o_key_value = r_out_key.value;

endmodule

`default_nettype wire
